// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/abpatch_pkg.sv =====
`default_nettype none
package abpatch_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 1048576;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OFF_W  = 20;
    localparam int unsigned LEN_W  = 21;
    localparam int unsigned POS_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CALC_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    localparam int unsigned OUT_DATA_W = ((OFF_W + LEN_W + 7) / 8) * 8;
    localparam int unsigned OUT_USER_W = 2;

    localparam logic [BYTE_W-1:0] START_TAIL = BYTE_W'(1);
    localparam logic [1:0]        ZRUN_MAX   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] patch_offset;
        logic [LEN_W-1:0] patch_length;
        logic             patch_valid;
        logic             frame_end;
        logic             frame_too_long;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/abpatch_in_reg.sv =====
`default_nettype none
module abpatch_in_reg
    import abpatch_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              advance,
    output logic                   in_valid,
    output logic [BYTE_W-1:0]      in_byte,
    output logic                   in_last
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    assign s_tready = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_last  = last_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/abpatch_core.sv =====
`default_nettype none
module abpatch_core
    import abpatch_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    output result_t                res
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        zrun_reg, zrun_next;
    logic [POS_W-1:0]  prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic              ovf_reg, ovf_next;

    logic              in_range;
    logic              ovf_now;
    logic              is_start;
    logic [CALC_W-1:0] idx_ext;
    logic [CALC_W-1:0] prev_ext;
    logic [CALC_W-1:0] end_len;
    logic [CALC_W-1:0] mid_len;

    assign in_range = pos_reg < POS_W'(MAX_FRAME_BYTES);
    assign ovf_now  = ovf_reg || !in_range;
    assign is_start = (in_byte == START_TAIL) && (zrun_reg == ZRUN_MAX) && !ovf_now;
    assign idx_ext  = CALC_W'(pos_reg);
    assign prev_ext = CALC_W'(prev_reg);
    // final unit: (idx + 1) - prev - 4; inner unit: (idx - 3) - prev - 4
    assign end_len  = idx_ext - prev_ext - CALC_W'(3);
    assign mid_len  = idx_ext - prev_ext - CALC_W'(7);

    always_comb begin
        pos_next       = pos_reg;
        zrun_next      = zrun_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        ovf_next       = ovf_now;
        res            = '0;
        if (in_last) begin
            res.valid          = 1'b1;
            res.frame_end      = 1'b1;
            res.frame_too_long = ovf_now;
            if (!ovf_now && have_prev_reg) begin
                res.patch_valid  = 1'b1;
                res.patch_offset = prev_reg[OFF_W-1:0];
                res.patch_length = end_len[LEN_W-1:0];
            end
            pos_next       = '0;
            zrun_next      = '0;
            prev_next      = '0;
            have_prev_next = 1'b0;
            ovf_next       = 1'b0;
        end else begin
            if (in_byte == '0) begin
                if (zrun_reg != ZRUN_MAX) begin
                    zrun_next = zrun_reg + 2'd1;
                end
            end else begin
                zrun_next = '0;
                if (is_start) begin
                    if (have_prev_reg) begin
                        res.valid        = 1'b1;
                        res.patch_valid  = 1'b1;
                        res.patch_offset = prev_reg[OFF_W-1:0];
                        res.patch_length = mid_len[LEN_W-1:0];
                    end
                    prev_next      = pos_reg - POS_W'(3);
                    have_prev_next = 1'b1;
                end
            end
            if (in_range) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            zrun_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end else if (fire) begin
            pos_reg       <= pos_next;
            zrun_reg      <= zrun_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/abpatch_out_reg.sv =====
`default_nettype none
module abpatch_out_reg
    import abpatch_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  fire,
    input  wire result_t               res,
    output logic                       load,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign load       = !valid_reg || m_tready;
    assign valid_next = load ? (fire && res.valid) : valid_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_DATA_W'({res_reg.patch_length, res_reg.patch_offset});
    assign m_tuser  = {res_reg.frame_too_long, res_reg.patch_valid};
    assign m_tlast  = res_reg.frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/annexb_start_code_to_length_patch.sv =====
// Annex B start code scanner that emits length-prefix patches.
//
// Input: one frame byte per beat on s_tdata, s_tlast on the final byte.
// Output: one beat per start code after the first, holding the offset of
// the previous start code and the big-endian unit length to write over its
// four bytes, plus one beat on every frame's last byte (m_tlast high) that
// closes the final unit or carries patch_valid low.
// Throughput: one byte per cycle while m_tready does not stall the output; the
// scan state updates between the input register and the output register.
// A result reaches m_tvalid through the input register, which takes its byte,
// and then the output register.
// Reset clears the frame state and the valid flags of both registers; the
// first byte can be taken as soon as reset is released.
// A stall on m_tready holds the pending result and stops the scan; s_tready
// drops only once the input register also holds a byte.
// Frames longer than MAX_FRAME_BYTES report frame_too_long on the last beat.
`default_nettype none
module annexb_start_code_to_length_patch
    import abpatch_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // data_byte
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // patch_offset, patch_length, zero pad
    output logic [OUT_USER_W-1:0]      m_tuser,   // patch_valid, frame_too_long
    output logic                       m_tlast
);

    logic              load;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              fire;
    result_t           res;

    assign fire = in_valid && load;

    abpatch_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (load),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_last  (in_last)
    );

    abpatch_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (in_byte),
        .in_last (in_last),
        .res     (res)
    );

    abpatch_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .res      (res),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/abpatch_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module abpatch_checker
    import abpatch_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [OUT_USER_W-1:0] m_tuser,
    input wire logic                  m_tlast
);

    `ASSERT_CLK(a_idle_after_reset, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK_RST(a_hold_on_stall, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_CLK_RST(a_no_patch_zero, aclk, aresetn,
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tlast)
    `ASSERT_CLK_RST(a_too_long_at_end, aclk, aresetn,
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])

endmodule

bind annexb_start_code_to_length_patch abpatch_checker u_abpatch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
